[hdl/egrl_pkg.sv]
// Shared types and constants of the exp-Golomb run/level decoder.
// No dependencies; imported by egrl_evt_if and the decoder core.
package egrl_pkg;

    // Positions in a block and the longest prefix a code may have
    localparam int BLOCK_LEN      = 63;
    localparam int MAX_ZEROS      = 20;
    // Most blocks a stream may hold, whatever block_count says
    localparam int MAX_BLOCKS     = 4096;

    localparam int KIND_W         = 3;
    localparam int BLK_IDX_W      = 12;
    localparam int POS_W          = 6;
    localparam int LEVEL_W        = 24;
    localparam int ZCNT_W         = 5;
    localparam int ORDER_W        = 2;
    localparam int BLK_CNT_W      = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 13;

    typedef enum logic [KIND_W-1:0] {
        EV_COEF      = 3'd0,
        EV_EOB       = 3'd1,
        EV_OVERRUN   = 3'd2,
        EV_TOO_LONG  = 3'd3,
        EV_TRUNCATED = 3'd4
    } t_event_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOLOMB_ORDER = 1'b0,
        CFG_BLOCK_COUNT  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_event_kind                event_kind;
        logic [BLK_IDX_W-1:0]       block_index;
        logic [POS_W-1:0]           position;
        logic [LEVEL_W-1:0]         level;
        logic                       block_last;
    } t_event;

endpackage

[hdl/egrl_bit_if.sv]
// Input channel of the decoder: one stream bit per request.
// Depends on nothing.
interface egrl_bit_if;
    logic valid;
    logic ready;
    logic stream_bit;
    logic last_bit;

    modport source (output valid, output stream_bit, output last_bit, input ready);
    modport sink   (input valid, input stream_bit, input last_bit, output ready);
endinterface

[hdl/egrl_evt_if.sv]
// Output channel of the decoder: one decoded event per request.
// Depends on egrl_pkg for the event kind type and field widths.
interface egrl_evt_if
    import egrl_pkg::*;
;
    logic                   valid;
    logic                   ready;
    t_event_kind            event_kind;
    logic [BLK_IDX_W-1:0]   block_index;
    logic [POS_W-1:0]       position;
    logic [LEVEL_W-1:0]     level;
    logic                   block_last;

    modport source (output valid, output event_kind, output block_index, output position,
                    output level, output block_last, input ready);
    modport sink   (input valid, input event_kind, input block_index, input position,
                    input level, input block_last, output ready);
endinterface

[hdl/exp_golomb_run_level_decoder_core.sv]
// Order-k exp-Golomb run/level decoder, one stream bit per cycle while i_bits.ready is high.
// Depends on egrl_pkg, egrl_bit_if and egrl_evt_if.
//
// Usage:
//   i_bits carries the coefficient stream, MSB first, one bit per request,
//   with last_bit flagging the final bit. o_evt carries decoded events:
//   coefficients (position, level), end of block, run overrun, code too
//   long and stream truncated, each tagged with its block index and a
//   block_last flag.
//   The config port writes golomb_order (index 0) or block_count (index 1)
//   on any cycle with i_cfg_we high; write only while the decoder is idle.
//   Throughput: one bit per cycle while the skid buffer is empty; the
//   decoder state is registered from a combinational next-state function.
//   Output: the event completed by an accepted bit is registered into the
//   output register, or into the skid buffer while o_evt is stalled.
//   Stall: an output register plus a one-entry skid buffer hold events;
//   i_bits.ready drops only when both are full.
//   Reset: clears the decoder state and both buffers, golomb_order to 0
//   and block_count to 864. After block_count blocks or the final bit,
//   further bits are accepted and dropped until reset.
module exp_golomb_run_level_decoder_core
    import egrl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    egrl_bit_if.sink                i_bits,
    egrl_evt_if.source              o_evt,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration
    logic [ORDER_W-1:0]     r_golomb_order;
    logic [BLK_CNT_W-1:0]   r_block_count;

    // Decoder state
    logic                   r_dec_level,   n_dec_level;
    logic [ZCNT_W-1:0]      r_zero_cnt,    n_zero_cnt;
    logic                   r_in_suffix,   n_in_suffix;
    logic [ZCNT_W-1:0]      r_suffix_left, n_suffix_left;
    logic [LEVEL_W-1:0]     r_suffix_val,  n_suffix_val;
    logic [LEVEL_W-1:0]     r_held_run,    n_held_run;
    logic [POS_W-1:0]       r_blk_pos,     n_blk_pos;
    logic [BLK_IDX_W-1:0]   r_blk_cnt,     n_blk_cnt;
    logic                   r_all_done,    n_all_done;
    logic [ORDER_W-1:0]     r_code_order,  n_code_order;

    // Output register and skid
    logic                   r_out_valid;
    t_event                 r_out;
    logic                   r_skid_valid;
    t_event                 r_skid;

    logic                   accept;
    logic                   active;
    logic                   code_done;
    logic                   close_blk;
    logic                   res_vld;
    t_event                 res;
    logic [ZCNT_W-1:0]      zc_inc;
    logic [LEVEL_W-1:0]     code_val;
    logic [LEVEL_W:0]       pos_sum;
    logic                   out_free;
    logic [BLK_CNT_W-1:0]   blk_limit;

    assign i_bits.ready = !r_skid_valid;
    assign accept       = i_bits.valid && !r_skid_valid;
    assign out_free     = !r_out_valid || o_evt.ready;

    always_comb begin
        n_dec_level   = r_dec_level;
        n_zero_cnt    = r_zero_cnt;
        n_in_suffix   = r_in_suffix;
        n_suffix_left = r_suffix_left;
        n_suffix_val  = r_suffix_val;
        n_held_run    = r_held_run;
        n_blk_pos     = r_blk_pos;
        n_blk_cnt     = r_blk_cnt;
        n_all_done    = r_all_done;
        n_code_order  = r_code_order;
        code_done     = 1'b0;
        close_blk     = 1'b0;
        res_vld       = 1'b0;
        res           = '{event_kind: EV_COEF, block_index: r_blk_cnt, position: '0,
                          level: '0, block_last: 1'b0};
        zc_inc        = r_zero_cnt + ZCNT_W'(1);
        code_val      = '0;
        pos_sum       = '0;
        // Clamp the block budget to the largest block index range
        blk_limit     = (r_block_count > BLK_CNT_W'(MAX_BLOCKS)) ? BLK_CNT_W'(MAX_BLOCKS)
                                                                 : r_block_count;

        // Block limit: a 13-bit compare covers counts above 4096 as well
        active = accept && !r_all_done && ({1'b0, r_blk_cnt} < r_block_count);

        if (active) begin
            if (!r_in_suffix) begin
                if (!i_bits.stream_bit) begin
                    if (zc_inc > ZCNT_W'(MAX_ZEROS)) begin
                        res_vld         = 1'b1;
                        res.event_kind  = EV_TOO_LONG;
                        res.block_last  = 1'b1;
                        close_blk       = 1'b1;
                    end else begin
                        n_zero_cnt = zc_inc;
                    end
                end else begin
                    // Prefix terminator: latch the order for this code
                    n_code_order  = r_golomb_order;
                    n_suffix_left = r_zero_cnt + {{(ZCNT_W-ORDER_W){1'b0}}, r_golomb_order};
                    n_suffix_val  = LEVEL_W'(1);
                    n_zero_cnt    = '0;
                    n_in_suffix   = 1'b1;
                    code_done     = (n_suffix_left == '0);
                end
            end else begin
                n_suffix_val  = {r_suffix_val[LEVEL_W-2:0], i_bits.stream_bit};
                n_suffix_left = r_suffix_left - ZCNT_W'(1);
                code_done     = (n_suffix_left == '0);
            end

            if (code_done) begin
                code_val     = n_suffix_val - (LEVEL_W'(1) << n_code_order);
                n_in_suffix  = 1'b0;
                n_suffix_val = '0;
                if (!r_dec_level) begin
                    n_held_run  = code_val;
                    n_dec_level = 1'b1;
                end else begin
                    n_dec_level = 1'b0;
                    n_held_run  = '0;
                    res_vld     = 1'b1;
                    pos_sum     = {1'b0, r_held_run} + (LEVEL_W+1)'(r_blk_pos);
                    if (r_held_run == '0 && code_val == '0) begin
                        res.event_kind = EV_EOB;
                        res.block_last = 1'b1;
                        close_blk      = 1'b1;
                    end else if (pos_sum >= (LEVEL_W+1)'(BLOCK_LEN)) begin
                        res.event_kind = EV_OVERRUN;
                        res.block_last = 1'b1;
                        close_blk      = 1'b1;
                    end else begin
                        res.position = pos_sum[POS_W-1:0];
                        res.level    = code_val;
                        if (pos_sum + (LEVEL_W+1)'(1) >= (LEVEL_W+1)'(BLOCK_LEN)) begin
                            res.block_last = 1'b1;
                            close_blk      = 1'b1;
                        end else begin
                            n_blk_pos = pos_sum[POS_W-1:0] + POS_W'(1);
                        end
                    end
                end
            end

            if (i_bits.last_bit) begin
                if (!res_vld && (n_dec_level || n_zero_cnt != '0 || n_in_suffix)) begin
                    res_vld        = 1'b1;
                    res.event_kind = EV_TRUNCATED;
                    res.block_last = 1'b1;
                    close_blk      = 1'b1;
                end
                n_all_done = 1'b1;
            end

            // Close the block: drop the pair in progress and advance the counter, or finish at the block limit
            if (close_blk) begin
                n_dec_level   = 1'b0;
                n_zero_cnt    = '0;
                n_in_suffix   = 1'b0;
                n_suffix_left = '0;
                n_suffix_val  = '0;
                n_held_run    = '0;
                n_blk_pos     = '0;
                if ({1'b0, r_blk_cnt} + BLK_CNT_W'(1) >= blk_limit) begin
                    n_all_done = 1'b1;
                end else begin
                    n_blk_cnt = r_blk_cnt + BLK_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_golomb_order <= '0;
            r_block_count  <= BLK_CNT_W'(864);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GOLOMB_ORDER: r_golomb_order <= i_cfg_data[ORDER_W-1:0];
                CFG_BLOCK_COUNT:  r_block_count  <= i_cfg_data[BLK_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_level   <= 1'b0;
            r_zero_cnt    <= '0;
            r_in_suffix   <= 1'b0;
            r_suffix_left <= '0;
            r_suffix_val  <= '0;
            r_held_run    <= '0;
            r_blk_pos     <= '0;
            r_blk_cnt     <= '0;
            r_all_done    <= 1'b0;
            r_code_order  <= '0;
        end else begin
            r_dec_level   <= n_dec_level;
            r_zero_cnt    <= n_zero_cnt;
            r_in_suffix   <= n_in_suffix;
            r_suffix_left <= n_suffix_left;
            r_suffix_val  <= n_suffix_val;
            r_held_run    <= n_held_run;
            r_blk_pos     <= n_blk_pos;
            r_blk_cnt     <= n_blk_cnt;
            r_all_done    <= n_all_done;
            r_code_order  <= n_code_order;
        end
    end

    // Output register with one-entry skid; new events never arrive while the skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_vld;
            end
        end else if (res_vld) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_vld) begin
                r_out <= res;
            end
        end else if (res_vld) begin
            r_skid <= res;
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.event_kind  = r_out.event_kind;
    assign o_evt.block_index = r_out.block_index;
    assign o_evt.position    = r_out.position;
    assign o_evt.level       = r_out.level;
    assign o_evt.block_last  = r_out.block_last;

endmodule
